// ===== hdl/edtrk_pkg.sv =====
package edtrk_pkg;

  localparam int CountWidth = 16;
  localparam int PosWidth   = 32;
  localparam int RegWidth   = 31;
  localparam int InWidth    = 24;
  localparam int OutWidth   = 40;

  typedef enum logic [1:0] {
    CFG_SET_DIR_THRESHOLD,
    CFG_INNER_BAND,
    CFG_KICK_BAND,
    CFG_RESOLUTION
  } cfg_idx_t;

  typedef struct packed {
    logic [RegWidth-1:0] set_dir_threshold;
    logic [RegWidth-1:0] inner_band;
    logic [RegWidth-1:0] kick_band;
    logic [RegWidth-1:0] resolution;
  } cfg_t;

  typedef struct packed {
    logic                       moved;
    logic                       req_unspool;
    logic                       req_spool;
    logic signed [PosWidth-1:0] reported_position;
  } result_t;

endpackage

// ===== hdl/edtrk_cfg.sv =====
module edtrk_cfg
  import edtrk_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_addr,
  input  logic [RegWidth-1:0] cfg_wdata,
  output cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_SET_DIR_THRESHOLD: cfg.set_dir_threshold <= cfg_wdata;
        CFG_INNER_BAND:        cfg.inner_band        <= cfg_wdata;
        CFG_KICK_BAND:         cfg.kick_band         <= cfg_wdata;
        CFG_RESOLUTION:        cfg.resolution        <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/edtrk_step.sv =====
module edtrk_step
  import edtrk_pkg::*;
(
  input  cfg_t                         cfg,
  input  logic signed [PosWidth-1:0]   stored_position,
  input  logic signed [PosWidth-1:0]   last_reported,
  input  logic signed [CountWidth-1:0] count_change,
  input  logic                         dir_flag,
  output result_t                      res,
  output logic signed [PosWidth-1:0]   stored_next,
  output logic signed [PosWidth-1:0]   last_next
);

  localparam int W = PosWidth + 2;
  localparam logic signed [W-1:0] SatMax = W'({1'b0, {(PosWidth-1){1'b1}}});
  localparam logic signed [W-1:0] SatMin = -SatMax - W'(1);

  logic signed [W-1:0]        raw;
  logic signed [PosWidth-1:0] sat;
  logic signed [W-1:0]        s, old, thr, inner, kick, reso, mag;
  logic signed [W-1:0]        neg_inner, neg_kick;
  logic                       moved, win_un, win_sp;
  logic signed [PosWidth-1:0] snap;

  always_comb begin
    raw = W'(count_change) + W'(stored_position);
    if (raw > SatMax) sat = SatMax[PosWidth-1:0];
    else if (raw < SatMin) sat = SatMin[PosWidth-1:0];
    else sat = raw[PosWidth-1:0];

    s         = W'(sat);
    old       = W'(last_reported);
    thr       = W'(cfg.set_dir_threshold);
    inner     = W'(cfg.inner_band);
    kick      = W'(cfg.kick_band);
    reso      = W'(cfg.resolution);
    neg_inner = -inner;
    neg_kick  = -kick;
    mag       = (s < 0) ? -s : s;

    moved  = (s != old);
    win_un = (s < -thr) && (s > -inner);
    win_sp = (s > thr) && (s < inner);

    snap = sat;
    if (s < old) begin
      if (s < kick && s > 0 && s > inner) snap = inner[PosWidth-1:0];
      if (s < -inner && s > -kick) snap = neg_kick[PosWidth-1:0];
    end else begin
      if (s > inner && s < kick) snap = kick[PosWidth-1:0];
      if (s > -kick && s < 0 && s < -inner) snap = neg_inner[PosWidth-1:0];
    end

    res.reported_position = sat;
    res.req_spool         = 1'b0;
    res.req_unspool       = 1'b0;
    res.moved             = moved;
    stored_next           = sat;
    last_next             = last_reported;

    if (moved) begin
      res.req_unspool = win_un && dir_flag;
      res.req_spool   = !win_un && win_sp && !dir_flag;
      stored_next     = snap;
      if (mag > reso) begin
        res.reported_position = (s < 0) ? PosWidth'(-reso) : PosWidth'(reso);
        stored_next           = res.reported_position;
      end
      last_next = res.reported_position;
    end
  end

endmodule

// ===== hdl/encoder_deadband_direction_tracker_unit.sv =====
// Encoder deadband direction tracker.
// Input stream (s_*): one word per poll, count change and direction flag.
// Output stream (m_*): one word per poll, the reported position with the
// spool/unspool requests and the moved flag.
// cfg_wr_en/cfg_addr/cfg_wdata write the four limit registers; write only
// while no word is in flight.
// A word accepted by the input handshake is registered in the input
// register, then processed into the output register once that register is
// empty or being read, and offered on m_tvalid from then on.
// Throughput: one word per cycle while m_tready stays high; the position
// accumulator and last reported value update as a word moves into the
// output register, so consecutive words see each other's state.
// Reset clears the limits, the position, the last reported value and both
// valid flags.
// When the receiver stalls, the output word holds; the input register takes
// one more word, then s_tready drops until m_tready returns.
module encoder_deadband_direction_tracker_unit
  import edtrk_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InWidth-1:0]  s_tdata,   // count_change[15:0], dir_flag[16]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutWidth-1:0] m_tdata,   // reported_position[31:0], req_spool[32],
                                         // req_unspool[33], moved[34]
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_addr,
  input  logic [RegWidth-1:0] cfg_wdata
);

  cfg_t                         cfg;
  logic                         in_valid;
  logic signed [CountWidth-1:0] in_count;
  logic                         in_dir;
  logic signed [PosWidth-1:0]   stored_position, last_reported;
  logic signed [PosWidth-1:0]   stored_next, last_next;
  result_t                      res_next, res;
  logic                         adv;

  edtrk_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  edtrk_step u_step (
    .cfg             (cfg),
    .stored_position (stored_position),
    .last_reported   (last_reported),
    .count_change    (in_count),
    .dir_flag        (in_dir),
    .res             (res_next),
    .stored_next     (stored_next),
    .last_next       (last_next)
  );

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;
  assign m_tdata  = OutWidth'(res);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      m_tvalid        <= 1'b0;
      stored_position <= '0;
      last_reported   <= '0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (adv) begin
        m_tvalid        <= 1'b1;
        stored_position <= stored_next;
        last_reported   <= last_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_count <= s_tdata[CountWidth-1:0];
      in_dir   <= s_tdata[CountWidth];
    end
    if (adv) res <= res_next;
  end

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input stalled without a blocked output");
  a_req_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res.req_spool && res.req_unspool))
    else $error("spool and unspool requested together");
  a_req_moved: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !res.moved) |-> (!res.req_spool && !res.req_unspool))
    else $error("direction request without movement");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !in_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule
